FILE: rtl/dlm_pkg.sv
// Shared types, codes and defaults of the file lock manager.
package dlm_pkg;

   // fixed field widths of the request and response items
   localparam int KIND_W  = 2;
   localparam int CONN_W  = 3;
   localparam int FIELD_W = 8;
   localparam int LEVEL_W = 3;

   // packed stream widths
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = KIND_W;
   localparam int RSP_DATA_W = 8;

   // parameter defaults
   localparam int CONNECTIONS_DEF  = 8;
   localparam int FILE_ID_BITS_DEF = 8;

   // lock levels
   localparam logic [LEVEL_W-1:0] LV_NONE      = 3'd0;
   localparam logic [LEVEL_W-1:0] LV_SHARED    = 3'd1;
   localparam logic [LEVEL_W-1:0] LV_RESERVED  = 3'd2;
   localparam logic [LEVEL_W-1:0] LV_PENDING   = 3'd3;
   localparam logic [LEVEL_W-1:0] LV_EXCLUSIVE = 3'd4;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_LOCK      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_UNLOCK    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RES_QUERY = 2'd2;
   localparam logic [KIND_W-1:0] KIND_OWN_QUERY = 2'd3;

   // response status codes
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_BUSY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load;    // capture the accepted request
      logic eval;    // read the slot table and register the conflict flags
      logic commit;  // update the slot and load the response register
   } cmd_type;

   typedef struct packed {
      logic out_free;  // response register can take a new result this cycle
   } sts_type;

endpackage

FILE: rtl/dlm_ctrl.sv
// Sequencer of the file lock manager: capture, evaluate, commit.
module dlm_ctrl import dlm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold until the response register frees up
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               req_tready = 1'b1;
               if (req_tvalid) begin
                  cmd.load = 1'b1;
                  state_in = ST_EVAL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/dlm_datapath.sv
// Slot table, conflict flags, lock decision and response register.
module dlm_datapath import dlm_pkg::*; #(
   parameter int CONNECTIONS  = CONNECTIONS_DEF,
   parameter int FILE_ID_BITS = FILE_ID_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int SLOT_W = $clog2(CONNECTIONS);
   localparam int WIDE_W = (FILE_ID_BITS > FIELD_W) ? FILE_ID_BITS : FIELD_W;

   // slot table
   logic [LEVEL_W-1:0]      level_ff [CONNECTIONS];
   logic [FILE_ID_BITS-1:0] file_ff  [CONNECTIONS];

   // captured request
   logic [KIND_W-1:0]       kind_ff;
   logic                    conn_ok_ff;
   logic [SLOT_W-1:0]       idx_ff;
   logic [FILE_ID_BITS-1:0] fid_ff;
   logic [LEVEL_W-1:0]      lvl_ff;

   // evaluated view
   logic [LEVEL_W-1:0]      cur_ff;
   logic [FILE_ID_BITS-1:0] efid_ff;
   logic                    oth_sh_ff;
   logic                    oth_res_ff;
   logic                    oth_pend_ff;

   // response register
   logic                    rsp_valid_ff;
   logic                    status_ff;
   logic [LEVEL_W-1:0]      held_ff;
   logic                    resv_ff;

   // request unpacking
   logic [CONN_W-1:0]        in_conn;
   logic [FIELD_W-1:0]       in_file;
   logic [LEVEL_W-1:0]       in_level;
   logic [SLOT_W+CONN_W-1:0] in_conn_wide;
   logic [WIDE_W-1:0]        in_file_wide;

   assign in_conn      = req_tdata[CONN_W-1:0];
   assign in_file      = req_tdata[CONN_W+FIELD_W-1:CONN_W];
   assign in_level     = req_tdata[CONN_W+FIELD_W+LEVEL_W-1:CONN_W+FIELD_W];
   assign in_conn_wide = (SLOT_W+CONN_W)'(in_conn);
   assign in_file_wide = WIDE_W'(in_file);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff    <= req_tuser;
         conn_ok_ff <= (32'(in_conn) < CONNECTIONS);
         idx_ff     <= in_conn_wide[SLOT_W-1:0];
         fid_ff     <= in_file_wide[FILE_ID_BITS-1:0];
         lvl_ff     <= (in_level > LV_EXCLUSIVE) ? LV_EXCLUSIVE : in_level;
      end
   end

   // evaluate: slot's own level, effective file, conflicts among other holders
   logic [LEVEL_W-1:0]      cur;
   logic [FILE_ID_BITS-1:0] efid;
   logic [CONNECTIONS-1:0]  hold_vec;
   logic [CONNECTIONS-1:0]  res_vec;
   logic [CONNECTIONS-1:0]  pend_vec;

   assign cur  = conn_ok_ff ? level_ff[idx_ff] : LV_NONE;
   assign efid = (cur != LV_NONE) ? file_ff[idx_ff] : fid_ff;

   always_comb begin
      for (int i = 0; i < CONNECTIONS; i++) begin
         hold_vec[i] = (level_ff[i] != LV_NONE) && (file_ff[i] == efid) &&
                       !(conn_ok_ff && (SLOT_W'(i) == idx_ff));
         res_vec[i]  = hold_vec[i] && (level_ff[i] >= LV_RESERVED);
         pend_vec[i] = hold_vec[i] && (level_ff[i] >= LV_PENDING);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         cur_ff      <= cur;
         efid_ff     <= efid;
         oth_sh_ff   <= |hold_vec;
         oth_res_ff  <= |res_vec;
         oth_pend_ff <= |pend_vec;
      end
   end

   // decide
   logic               wr_en;
   logic [LEVEL_W-1:0] new_level;
   logic               status;

   always_comb begin
      wr_en     = 1'b0;
      new_level = cur_ff;
      status    = STATUS_DONE;
      case (kind_ff)
         KIND_LOCK: begin
            if (lvl_ff > cur_ff) begin
               if ((lvl_ff == LV_SHARED) ? oth_pend_ff : oth_res_ff) begin
                  status = STATUS_BUSY;
               end else begin
                  wr_en = 1'b1;
                  if (lvl_ff == LV_EXCLUSIVE) begin
                     // park at pending while other readers remain
                     new_level = oth_sh_ff ? LV_PENDING : LV_EXCLUSIVE;
                     status    = oth_sh_ff ? STATUS_BUSY : STATUS_DONE;
                  end else begin
                     new_level = lvl_ff;
                  end
               end
            end
         end
         KIND_UNLOCK: begin
            wr_en     = 1'b1;
            new_level = lvl_ff;
         end
         KIND_RES_QUERY, KIND_OWN_QUERY: begin
            wr_en = 1'b0;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CONNECTIONS; i++) begin
            level_ff[i] <= LV_NONE;
         end
      end else if (cmd.commit && wr_en && conn_ok_ff) begin
         level_ff[idx_ff] <= new_level;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en && conn_ok_ff) begin
         file_ff[idx_ff] <= efid_ff;
      end
   end

   // response register
   logic rsp_valid_in;

   assign rsp_valid_in = cmd.commit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= conn_ok_ff ? status : STATUS_DONE;
         held_ff   <= conn_ok_ff ? new_level : LV_NONE;
         resv_ff   <= oth_res_ff || (conn_ok_ff && (new_level >= LV_RESERVED));
      end
   end

   assign sts.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {(RSP_DATA_W - LEVEL_W - 2)'(0), resv_ff, held_ff, status_ff};

endmodule

FILE: rtl/db_file_lock_manager.sv
// Top level of the five-level database file lock manager.
//
// Lock manager for up to CONNECTIONS connection slots, each holding one of the
// levels none, shared, reserved, pending, exclusive on one numeric file id.
// Every accepted request returns exactly one response. A request is first
// evaluated, reading the slot table and registering the conflict flags of all
// other holders (compared in parallel), then committed, which decides,
// updates the slot and loads the response register. The next request is
// taken at commit, not during evaluation, and the response is registered at
// commit. While a response waits on rsp_tready the commit cycle holds and no
// further request is taken. A slot that holds a lock stays bound to its
// recorded file; a slot at none takes the request's file id.
// Levels above exclusive saturate to exclusive; a connection number at or
// above CONNECTIONS changes nothing and reports held level none. Lock requests
// that raise the level can be refused with status busy; a request for
// exclusive that meets remaining readers leaves the slot at pending.
module db_file_lock_manager import dlm_pkg::*; #(
   parameter int CONNECTIONS  = CONNECTIONS_DEF,
   parameter int FILE_ID_BITS = FILE_ID_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] connection, [10:3] file_id, [13:11] level, [15:14] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] kind
   input  logic [REQ_USER_W-1:0] req_tuser,
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] status, [3:1] held_level, [4] reserved_seen, [7:5] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   cmd_type cmd;
   sts_type sts;

   // sequence capture, evaluate and commit
   dlm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // hold the slot table and build each response
   dlm_datapath #(
      .CONNECTIONS  (CONNECTIONS),
      .FILE_ID_BITS (FILE_ID_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: rtl/dlm_checker.sv
// Port-level checks of the file lock manager and their binding.
module dlm_checker import dlm_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready
);

   // a stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // an accepted request is evaluated in the next cycle, so no request is taken then
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken during evaluation");

   // every busy response also reports a holder at reserved or above
   a_busy_resv: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[0] == STATUS_BUSY) |-> rsp_tdata[4])
      else $error("busy without a reserved holder");

   // an exclusive holder counts as reserved or above
   a_excl_resv: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[3:1] == LV_EXCLUSIVE) |-> rsp_tdata[4])
      else $error("exclusive holder not reported as reserved");

endmodule

bind db_file_lock_manager dlm_checker u_dlm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

FILE: tb/db_file_lock_manager_tb.sv
// Self-checking testbench of the five-level database file lock manager.
module db_file_lock_manager_tb;
   import dlm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_CONN     = CONNECTIONS_DEF;
   localparam int DIR_ROWS   = 24;
   localparam int RAND_ITEMS = 1950;
   // extra wait after the last expected response, to catch stray ones
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_OFF_AT  = 600;
   localparam int HOLD_OFF_LEN = 400;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CONN_W-1:0]  connection;
      logic [FIELD_W-1:0] file_id;
      logic [LEVEL_W-1:0] level;
   } lock_req_type;

   typedef struct packed {
      logic               status;
      logic [LEVEL_W-1:0] held_level;
      logic               reserved_seen;
   } lock_rsp_type;

   // one directed step; typed rows carry their own expected response
   typedef struct packed {
      lock_req_type req;
      logic         typed;
      lock_rsp_type rsp;
   } lock_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // shadow copy of the slot table
   logic [LEVEL_W-1:0] shadow_level [N_CONN];
   logic [FIELD_W-1:0] shadow_file  [N_CONN];

   lock_rsp_type due_rsp_q [$];
   int           err_cnt   = 0;
   int           rsp_seen  = 0;

   db_file_lock_manager i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Report whether any holder of fid, other than slot skip, sits at floor_lvl or above.
   function automatic logic holder_at_or_above(logic [FIELD_W-1:0] fid, int skip,
                                               logic [LEVEL_W-1:0] floor_lvl);
      int i;
      for (i = 0; i < N_CONN; i++) begin
         if (i != skip && shadow_level[i] != LV_NONE && shadow_file[i] == fid &&
             shadow_level[i] >= floor_lvl)
            return 1'b1;
      end
      return 1'b0;
   endfunction

   // Apply one request to the shadow table and return the response it earns.
   function automatic lock_rsp_type lock_outcome(lock_req_type r);
      lock_rsp_type       o;
      logic [LEVEL_W-1:0] want;
      logic [LEVEL_W-1:0] cur;
      logic [FIELD_W-1:0] fid;
      logic               busy;
      int                 c;
      want = (r.level > LV_EXCLUSIVE) ? LV_EXCLUSIVE : r.level;
      fid  = r.file_id;
      c    = r.connection;
      o.status     = STATUS_DONE;
      o.held_level = LV_NONE;
      if (c < N_CONN) begin
         cur = shadow_level[c];
         // a slot holding a lock stays on its recorded file
         if (cur != LV_NONE)
            fid = shadow_file[c];
         if (r.kind == KIND_LOCK && want > cur) begin
            // shared only fears pending and above; everything else fears reserved
            if (want == LV_SHARED)
               busy = holder_at_or_above(fid, c, LV_PENDING);
            else
               busy = holder_at_or_above(fid, c, LV_RESERVED);
            if (busy) begin
               o.status = STATUS_BUSY;
            end else begin
               shadow_file[c] = fid;
               if (want == LV_EXCLUSIVE) begin
                  // record pending first; stay there while readers remain
                  shadow_level[c] = LV_PENDING;
                  if (holder_at_or_above(fid, c, LV_SHARED))
                     o.status = STATUS_BUSY;
                  else
                     shadow_level[c] = LV_EXCLUSIVE;
               end else begin
                  shadow_level[c] = want;
               end
            end
         end else if (r.kind == KIND_UNLOCK) begin
            shadow_file[c]  = fid;
            shadow_level[c] = want;
         end
         o.held_level = shadow_level[c];
      end
      o.reserved_seen = holder_at_or_above(fid, N_CONN, LV_RESERVED);
      return o;
   endfunction

   // Directed table: reset state, conflicts, pending, saturation, file binding.
   function automatic lock_row_type directed_row(int idx);
      lock_row_type row;
      case (idx)
         // fresh table: nothing held anywhere
         0:  row = '{'{KIND_OWN_QUERY, 3'd0, 8'h00, LV_NONE}, 1'b1,
                     '{STATUS_DONE, LV_NONE, 1'b0}};
         1:  row = '{'{KIND_RES_QUERY, 3'd7, 8'hFF, LV_NONE}, 1'b1,
                     '{STATUS_DONE, LV_NONE, 1'b0}};
         2:  row = '{'{KIND_LOCK, 3'd0, 8'h55, LV_SHARED}, 1'b1,
                     '{STATUS_DONE, LV_SHARED, 1'b0}};
         3:  row = '{'{KIND_LOCK, 3'd1, 8'h55, LV_SHARED}, 1'b0, '0};
         4:  row = '{'{KIND_LOCK, 3'd1, 8'h55, LV_RESERVED}, 1'b0, '0};
         // second writer on the same file is refused
         5:  row = '{'{KIND_LOCK, 3'd2, 8'h55, LV_RESERVED}, 1'b1,
                     '{STATUS_BUSY, LV_NONE, 1'b1}};
         6:  row = '{'{KIND_LOCK, 3'd0, 8'h55, LV_EXCLUSIVE}, 1'b1,
                     '{STATUS_BUSY, LV_SHARED, 1'b1}};
         7:  row = '{'{KIND_LOCK, 3'd2, 8'h55, LV_SHARED}, 1'b0, '0};
         // level above exclusive; readers remain, so the slot parks at pending
         8:  row = '{'{KIND_LOCK, 3'd1, 8'h55, 3'd7}, 1'b0, '0};
         // a new reader is shut out by pending
         9:  row = '{'{KIND_LOCK, 3'd3, 8'h55, LV_SHARED}, 1'b1,
                     '{STATUS_BUSY, LV_NONE, 1'b1}};
         // a holding slot ignores the request's file id
         10: row = '{'{KIND_UNLOCK, 3'd0, 8'hAA, LV_NONE}, 1'b0, '0};
         11: row = '{'{KIND_UNLOCK, 3'd2, 8'h00, LV_NONE}, 1'b0, '0};
         12: row = '{'{KIND_LOCK, 3'd1, 8'h55, LV_EXCLUSIVE}, 1'b0, '0};
         // lower request changes nothing
         13: row = '{'{KIND_LOCK, 3'd1, 8'h55, LV_SHARED}, 1'b0, '0};
         14: row = '{'{KIND_UNLOCK, 3'd1, 8'h55, 3'd5}, 1'b1,
                     '{STATUS_DONE, LV_EXCLUSIVE, 1'b1}};
         15: row = '{'{KIND_RES_QUERY, 3'd5, 8'h55, LV_NONE}, 1'b0, '0};
         16: row = '{'{KIND_OWN_QUERY, 3'd1, 8'hAA, 3'd6}, 1'b0, '0};
         17: row = '{'{KIND_LOCK, 3'd4, 8'hAA, LV_EXCLUSIVE}, 1'b0, '0};
         18: row = '{'{KIND_UNLOCK, 3'd1, 8'h55, LV_RESERVED}, 1'b0, '0};
         19: row = '{'{KIND_UNLOCK, 3'd1, 8'h55, LV_NONE}, 1'b0, '0};
         20: row = '{'{KIND_UNLOCK, 3'd4, 8'hAA, 3'd6}, 1'b0, '0};
         21: row = '{'{KIND_UNLOCK, 3'd4, 8'hAA, LV_NONE}, 1'b0, '0};
         // pending asked for directly on an empty file
         22: row = '{'{KIND_LOCK, 3'd7, 8'hFF, LV_PENDING}, 1'b1,
                     '{STATUS_DONE, LV_PENDING, 1'b1}};
         default: row = '{'{KIND_UNLOCK, 3'd7, 8'hFF, LV_NONE}, 1'b0, '0};
      endcase
      return row;
   endfunction

   // Build a random request on a small pool of files so that slots collide.
   function automatic lock_req_type random_request();
      lock_req_type r;
      int           p;
      r.connection = CONN_W'($urandom_range(0, N_CONN - 1));
      p = $urandom_range(0, 99);
      if (p < 8)
         r.file_id = FIELD_W'($urandom_range(0, 255));
      else if (p < 45)
         r.file_id = 8'h3C;
      else if (p < 80)
         r.file_id = 8'hC3;
      else
         r.file_id = 8'h00;
      p = $urandom_range(0, 99);
      if (p < 52)
         r.kind = KIND_LOCK;
      else if (p < 78)
         r.kind = KIND_UNLOCK;
      else if (p < 89)
         r.kind = KIND_RES_QUERY;
      else
         r.kind = KIND_OWN_QUERY;
      p = $urandom_range(0, 99);
      if (p < 7)
         r.level = LEVEL_W'($urandom_range(5, 7));
      else if (r.kind == KIND_UNLOCK && p < 55)
         r.level = LV_NONE;
      else if (r.kind == KIND_LOCK)
         r.level = LEVEL_W'($urandom_range(1, 4));
      else
         r.level = LEVEL_W'($urandom_range(0, 4));
      return r;
   endfunction

   // Mostly back to back, sometimes a short pause, rarely a long one.
   function automatic int idle_cycles();
      int p;
      p = $urandom_range(0, 99);
      if (p < 65)
         return 0;
      else if (p < 93)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // Offer one request, hold it until accepted, then queue its expected response.
   task automatic offer_request(lock_req_type r, logic typed, lock_rsp_type typed_rsp);
      lock_rsp_type predicted;
      int           gap;
      req_tdata  <= {2'b00, r.level, r.file_id, r.connection};
      req_tuser  <= r.kind;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      // advance the shadow table even when the row states its own answer
      predicted = lock_outcome(r);
      due_rsp_q.push_back(typed ? typed_rsp : predicted);
      gap = idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stimulus: reset, directed table, random requests, drain, verdict.
   initial begin
      lock_row_type row;
      int           i;
      for (i = 0; i < N_CONN; i++) begin
         shadow_level[i] = LV_NONE;
         shadow_file[i]  = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (i = 0; i < DIR_ROWS; i++) begin
         row = directed_row(i);
         offer_request(row.req, row.typed, row.rsp);
      end
      for (i = 0; i < RAND_ITEMS; i++)
         offer_request(random_request(), 1'b0, '0);
      req_tvalid <= 1'b0;
      // wait out every queued response, then a few more cycles for strays
      while (due_rsp_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_cnt == 0 && due_rsp_q.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Response side: random back-pressure, one long hold-off, field-wise compare.
   initial begin
      lock_rsp_type want;
      lock_rsp_type got;
      int           stall;
      bit           held_off;
      held_off = 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (!held_off && rsp_seen == HOLD_OFF_AT) begin
            // hold off long enough for the block to fill and stall requests
            stall    = HOLD_OFF_LEN;
            held_off = 1'b1;
         end else begin
            stall = idle_cycles();
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid)
            @(posedge clock);
         rsp_seen++;
         got.status        = rsp_tdata[0];
         got.held_level    = rsp_tdata[3:1];
         got.reserved_seen = rsp_tdata[4];
         if (due_rsp_q.size() == 0) begin
            $display("%0t: response with none expected: tdata %h", $realtime, rsp_tdata);
            err_cnt++;
         end else begin
            want = due_rsp_q.pop_front();
            if (got.status !== want.status) begin
               $display("%0t: status mismatch: expected %0d actual %0d",
                        $realtime, want.status, got.status);
               err_cnt++;
            end
            if (got.held_level !== want.held_level) begin
               $display("%0t: held_level mismatch: expected %0d actual %0d",
                        $realtime, want.held_level, got.held_level);
               err_cnt++;
            end
            if (got.reserved_seen !== want.reserved_seen) begin
               $display("%0t: reserved_seen mismatch: expected %0d actual %0d",
                        $realtime, want.reserved_seen, got.reserved_seen);
               err_cnt++;
            end
         end
      end
   end

   // Timeout: several times the slowest legal run.
   initial begin
      #8_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: sim.f
rtl/dlm_pkg.sv
rtl/dlm_ctrl.sv
rtl/dlm_datapath.sv
rtl/db_file_lock_manager.sv
rtl/dlm_checker.sv
tb/db_file_lock_manager_tb.sv
